>>> sv/keyed_square_bigram_cipher_assert.svh
// Assertion macros for the keyed square bigram cipher.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef KEYED_SQUARE_BIGRAM_CIPHER_ASSERT_SVH
`define KEYED_SQUARE_BIGRAM_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KSBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ksbc_pkg.sv
// Shared types, constants and symbol helpers for the keyed square bigram cipher.
// No dependencies; used by ksbc_square, ksbc_ctrl and the top level.
`default_nettype none

package ksbc_pkg;

    localparam int unsigned NSYM  = 36;
    localparam int unsigned SYM_W = 6;
    localparam int unsigned SIDE  = 6;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [2:0]       rc_t;

    // Pad symbol for an odd leftover: 'X'.
    localparam sym_t PAD_SYM = 6'd23;

    typedef enum logic [1:0] {
        FN_KEY    = 2'd0,
        FN_FINISH = 2'd1,
        FN_TEXT   = 2'd2,
        FN_END    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_CROSS,
        ST_EMIT0,
        ST_EMIT1
    } state_t;

    typedef struct packed {
        logic ok;
        sym_t sym;
    } sym_res_t;

    // Requests from the sequencer to the square storage.
    typedef struct packed {
        logic place_en;
        sym_t place_sym;
        logic look_en;
        sym_t look_a;
        sym_t look_b;
        logic cross_en;
        sym_t cell_x;
        sym_t cell_y;
    } sq_ctl_t;

    function automatic sym_res_t to_symbol(input logic [7:0] c, input logic fold);
        sym_res_t r;
        r.ok  = 1'b0;
        r.sym = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.ok  = 1'b1;
            r.sym = SYM_W'(c - 8'h41);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.ok  = 1'b1;
            r.sym = SYM_W'(c - 8'h30 + 8'd26);
        end else if (fold && c >= 8'h61 && c <= 8'h7A) begin
            r.ok  = 1'b1;
            r.sym = SYM_W'(c - 8'h61);
        end
        return r;
    endfunction

    function automatic logic [7:0] to_ascii(input sym_t s);
        logic [7:0] r;
        if (s < SYM_W'(26)) begin
            r = 8'h41 + {2'b00, s};
        end else begin
            r = 8'h30 + {2'b00, s} - 8'd26;
        end
        return r;
    endfunction

    // Row of a cell: c/6 as (c*43)>>8, exact for every cell below 36.
    function automatic rc_t cell_row(input sym_t c);
        logic [11:0] prod;
        prod = {6'd0, c} * 12'd43;
        return prod[10:8];
    endfunction

    function automatic rc_t cell_col(input sym_t c, input rc_t row);
        sym_t base;
        sym_t diff;
        base = ({3'd0, row} << 2) + ({3'd0, row} << 1);
        diff = c - base;
        return diff[2:0];
    endfunction

    function automatic sym_t cell_at(input rc_t row, input rc_t col);
        return ({3'd0, row} << 2) + ({3'd0, row} << 1) + {3'd0, col};
    endfunction

endpackage

`default_nettype wire

>>> sv/ksbc_square.sv
// Square storage: cell-to-symbol and symbol-to-cell memories, placed bits, fill count.
// Depends on ksbc_pkg.
`default_nettype none

module ksbc_square
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ksbc_pkg::sq_ctl_t ctl,
    output logic [5:0]            sc_rd_a,
    output logic [5:0]            sc_rd_b,
    output logic [5:0]            cs_rd_x,
    output logic [5:0]            cs_rd_y
);

    logic [5:0] cell_symbol [ksbc_pkg::NSYM];
    logic [5:0] symbol_cell [ksbc_pkg::NSYM];

    logic [ksbc_pkg::NSYM-1:0] placed_reg;
    logic [ksbc_pkg::NSYM-1:0] placed_next;
    logic [5:0]                filled_reg;
    logic [5:0]                filled_next;
    logic                      wr_en;

    assign wr_en = ctl.place_en && !placed_reg[ctl.place_sym]
                   && (filled_reg < 6'(ksbc_pkg::NSYM));

    always_comb
    begin
        placed_next = placed_reg;
        filled_next = filled_reg;
        if (wr_en)
        begin
            placed_next[ctl.place_sym] = 1'b1;
            filled_next = filled_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            placed_reg <= '0;
            filled_reg <= '0;
        end
        else
        begin
            placed_reg <= placed_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_symbol[filled_reg]    <= ctl.place_sym;
            symbol_cell[ctl.place_sym] <= filled_reg;
        end
        if (ctl.look_en)
        begin
            sc_rd_a <= symbol_cell[ctl.look_a];
            sc_rd_b <= symbol_cell[ctl.look_b];
        end
        if (ctl.cross_en)
        begin
            cs_rd_x <= cell_symbol[ctl.cell_x];
            cs_rd_y <= cell_symbol[ctl.cell_y];
        end
    end

endmodule

`default_nettype wire

>>> sv/ksbc_ctrl.sv
// Sequencer: decodes items, walks the finish fill, forms pairs and steps the lookups.
// Depends on ksbc_pkg and keyed_square_bigram_cipher_assert.svh.
`default_nettype none

`include "keyed_square_bigram_cipher_assert.svh"

module ksbc_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [7:0]        char_in,
    output ksbc_pkg::sq_ctl_t      ctl,
    input  wire logic [5:0]        sc_rd_a,
    input  wire logic [5:0]        sc_rd_b,
    input  wire logic [5:0]        cs_rd_x,
    input  wire logic [5:0]        cs_rd_y,
    output logic                   emit_req,
    output logic [7:0]             emit_char,
    output logic                   emit_last,
    input  wire logic              emit_take
);

    ksbc_pkg::state_t state_reg, state_next;
    ksbc_pkg::func_t  func_reg, func_next;
    logic [7:0]       char_reg, char_next;
    logic             key_done_reg, key_done_next;
    logic             pend_valid_reg, pend_valid_next;
    ksbc_pkg::sym_t   pend_sym_reg, pend_sym_next;
    ksbc_pkg::sym_t   cnt_reg, cnt_next;

    ksbc_pkg::sym_res_t key_sym;
    ksbc_pkg::sym_res_t txt_sym;
    ksbc_pkg::rc_t      row_a, col_a, row_b, col_b;
    logic               accept;

    assign accept  = in_valid && !in_stall;
    assign key_sym = ksbc_pkg::to_symbol(char_reg, 1'b0);
    assign txt_sym = ksbc_pkg::to_symbol(char_reg, 1'b1);

    assign row_a = ksbc_pkg::cell_row(sc_rd_a);
    assign col_a = ksbc_pkg::cell_col(sc_rd_a, row_a);
    assign row_b = ksbc_pkg::cell_row(sc_rd_b);
    assign col_b = ksbc_pkg::cell_col(sc_rd_b, row_b);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ksbc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ksbc_pkg::ST_DECODE;
                end
            end
            ksbc_pkg::ST_DECODE:
            begin
                state_next = ksbc_pkg::ST_IDLE;
                case (func_reg)
                    ksbc_pkg::FN_FINISH:
                    begin
                        if (!key_done_reg)
                        begin
                            state_next = ksbc_pkg::ST_FILL;
                        end
                    end
                    ksbc_pkg::FN_TEXT:
                    begin
                        if (key_done_reg && txt_sym.ok && pend_valid_reg)
                        begin
                            state_next = ksbc_pkg::ST_CROSS;
                        end
                    end
                    ksbc_pkg::FN_END:
                    begin
                        if (key_done_reg && pend_valid_reg)
                        begin
                            state_next = ksbc_pkg::ST_CROSS;
                        end
                    end
                    default:
                    begin
                        state_next = ksbc_pkg::ST_IDLE;
                    end
                endcase
            end
            ksbc_pkg::ST_FILL:
            begin
                if (cnt_reg == 6'(ksbc_pkg::NSYM - 1))
                begin
                    state_next = ksbc_pkg::ST_IDLE;
                end
            end
            ksbc_pkg::ST_CROSS:
            begin
                state_next = ksbc_pkg::ST_EMIT0;
            end
            ksbc_pkg::ST_EMIT0:
            begin
                if (emit_take)
                begin
                    state_next = ksbc_pkg::ST_EMIT1;
                end
            end
            ksbc_pkg::ST_EMIT1:
            begin
                if (emit_take)
                begin
                    state_next = ksbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ksbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        func_next       = func_reg;
        char_next       = char_reg;
        key_done_next   = key_done_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        cnt_next        = cnt_reg;
        ctl             = '0;
        in_stall        = 1'b1;
        emit_req        = 1'b0;
        emit_char       = ksbc_pkg::to_ascii(cs_rd_x);
        emit_last       = 1'b0;
        case (state_reg)
            ksbc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    func_next = ksbc_pkg::func_t'(func);
                    char_next = char_in;
                end
            end
            ksbc_pkg::ST_DECODE:
            begin
                case (func_reg)
                    ksbc_pkg::FN_KEY:
                    begin
                        ctl.place_en  = !key_done_reg && key_sym.ok;
                        ctl.place_sym = key_sym.sym;
                    end
                    ksbc_pkg::FN_FINISH:
                    begin
                        cnt_next = '0;
                    end
                    ksbc_pkg::FN_TEXT:
                    begin
                        if (key_done_reg && txt_sym.ok)
                        begin
                            if (pend_valid_reg)
                            begin
                                pend_valid_next = 1'b0;
                                ctl.look_en     = 1'b1;
                                ctl.look_a      = pend_sym_reg;
                                ctl.look_b      = txt_sym.sym;
                            end
                            else
                            begin
                                pend_valid_next = 1'b1;
                                pend_sym_next   = txt_sym.sym;
                            end
                        end
                    end
                    ksbc_pkg::FN_END:
                    begin
                        if (key_done_reg && pend_valid_reg)
                        begin
                            pend_valid_next = 1'b0;
                            ctl.look_en     = 1'b1;
                            ctl.look_a      = pend_sym_reg;
                            ctl.look_b      = ksbc_pkg::PAD_SYM;
                        end
                    end
                    default:
                    begin
                        ctl.look_en = 1'b0;
                    end
                endcase
            end
            ksbc_pkg::ST_FILL:
            begin
                // Unplaced symbols land in alphabet order; placed ones are skipped.
                ctl.place_en  = 1'b1;
                ctl.place_sym = cnt_reg;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ksbc_pkg::NSYM - 1))
                begin
                    key_done_next = 1'b1;
                end
            end
            ksbc_pkg::ST_CROSS:
            begin
                ctl.cross_en = 1'b1;
                ctl.cell_x   = ksbc_pkg::cell_at(row_a, col_b);
                ctl.cell_y   = ksbc_pkg::cell_at(row_b, col_a);
            end
            ksbc_pkg::ST_EMIT0:
            begin
                emit_req  = 1'b1;
                emit_char = ksbc_pkg::to_ascii(cs_rd_x);
                emit_last = 1'b0;
            end
            ksbc_pkg::ST_EMIT1:
            begin
                emit_req  = 1'b1;
                emit_char = ksbc_pkg::to_ascii(cs_rd_y);
                emit_last = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ksbc_pkg::ST_IDLE;
            key_done_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_sym_reg   <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            key_done_reg   <= key_done_next;
            pend_valid_reg <= pend_valid_next;
            pend_sym_reg   <= pend_sym_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        char_reg <= char_next;
    end

    `KSBC_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != ksbc_pkg::ST_IDLE,
        "accepted item did not start work")
    `KSBC_ASSERT_IMPL(a_fill_before_done, clk, rst_n, state_reg == ksbc_pkg::ST_FILL,
        !key_done_reg, "fill pass running on a finished square")
    `KSBC_ASSERT_IMPL(a_cross_pair_used, clk, rst_n, state_reg == ksbc_pkg::ST_CROSS,
        !pend_valid_reg, "held symbol not released by its pair")
    `KSBC_ASSERT_IMPL(a_emit_after_key, clk, rst_n, emit_req, key_done_reg,
        "ciphertext produced before the square was finished")

endmodule

`default_nettype wire

>>> sv/keyed_square_bigram_cipher.sv
// Keyed 6x6 square bigram cipher over A-Z and 0-9: an input item is taken only
// while the sequencer is idle. A finish item walks the fill over the 36 symbols,
// one symbol per cycle, and an item that completes a pair waits on the two dependent
// lookups in the symbol-to-cell and cell-to-symbol memories and then on the output
// register for both bytes, so an output stall can hold it.
// Results leave through a one-item output register, so the next item is accepted
// while the second byte of a pair still waits.
// Depends on ksbc_pkg, ksbc_square and ksbc_ctrl.
`default_nettype none

module keyed_square_bigram_cipher
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    input  wire logic [7:0] char_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      char_out,
    output logic            last
);

    ksbc_pkg::sq_ctl_t ctl;
    logic [5:0]        sc_rd_a, sc_rd_b, cs_rd_x, cs_rd_y;
    logic              emit_req, emit_last, emit_take;
    logic [7:0]        emit_char;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_out_reg;
    logic              last_reg;

    ksbc_square u_square
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .sc_rd_a (sc_rd_a),
        .sc_rd_b (sc_rd_b),
        .cs_rd_x (cs_rd_x),
        .cs_rd_y (cs_rd_y)
    );

    ksbc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .char_in   (char_in),
        .ctl       (ctl),
        .sc_rd_a   (sc_rd_a),
        .sc_rd_b   (sc_rd_b),
        .cs_rd_x   (cs_rd_x),
        .cs_rd_y   (cs_rd_y),
        .emit_req  (emit_req),
        .emit_char (emit_char),
        .emit_last (emit_last),
        .emit_take (emit_take)
    );

    // The output slot can be loaded when empty or when its item leaves this cycle.
    assign emit_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_req && emit_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_req && emit_take)
        begin
            char_out_reg <= emit_char;
            last_reg     <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> dv/keyed_square_bigram_cipher_test.sv
// Self-checking testbench for keyed_square_bigram_cipher: loads a key square, then
// streams text, end and stray key and finish items and checks every ciphertext byte against a local predictor.
// Depends on ksbc_pkg and the keyed_square_bigram_cipher RTL.
`default_nettype none

module keyed_square_bigram_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ksbc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEM_COUNT   = 550;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        func_t      fn;
        logic [7:0] ch;
    } cipher_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } cipher_byte_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } stall_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    func_t      func      = FN_KEY;
    logic [7:0] char_in   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] char_out;
    logic       last;

    cipher_item_t items_to_send[$];
    cipher_byte_t cipher_bytes_due[$];

    // Local copy of the key square.
    sym_t        sq_sym  [NSYM];
    sym_t        sq_cell [NSYM];
    bit          sq_used [NSYM];
    int unsigned sq_count     = 0;
    bit          square_ready = 1'b0;
    bit          held_ok      = 1'b0;
    sym_t        held_sym     = '0;

    int          mismatches   = 0;
    int          idle_cycles  = 0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    stall_mode_t stall_mode   = STALL_NONE;
    int          mode_left    = 0;
    int          run_left     = 0;
    bit          run_level    = 1'b0;

    keyed_square_bigram_cipher uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last      (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Returns the symbol number of a byte, or -1 when the byte is not a symbol.
    function automatic int char_symbol(logic [7:0] c, bit fold);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return int'(c - 8'h41);
        end
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c - 8'h30) + 26;
        end
        if (fold && c >= 8'h61 && c <= 8'h7A)
        begin
            return int'(c - 8'h61);
        end
        return -1;
    endfunction

    function automatic logic [7:0] symbol_char(sym_t s);
        if (s < 26)
        begin
            return 8'h41 + 8'(s);
        end
        return 8'h30 + 8'(s) - 8'd26;
    endfunction

    function automatic void place_symbol(sym_t s);
        if (!sq_used[s] && sq_count < NSYM)
        begin
            sq_sym[sq_count] = s;
            sq_cell[s]       = sym_t'(sq_count);
            sq_used[s]       = 1'b1;
            sq_count++;
        end
    endfunction

    // Opposite corners of the rectangle spanned by the two symbols' cells.
    function automatic void emit_pair(sym_t a, sym_t b);
        int ca;
        int cb;
        ca = sq_cell[a];
        cb = sq_cell[b];
        cipher_bytes_due.push_back('{symbol_char(sq_sym[(ca / SIDE) * SIDE + cb % SIDE]), 1'b0});
        cipher_bytes_due.push_back('{symbol_char(sq_sym[(cb / SIDE) * SIDE + ca % SIDE]), 1'b1});
    endfunction

    function automatic void encipher_item(func_t fn, logic [7:0] c);
        int s;
        case (fn)
            FN_KEY:
            begin
                s = char_symbol(c, 1'b0);
                if (!square_ready && s >= 0)
                begin
                    place_symbol(sym_t'(s));
                end
            end
            FN_FINISH:
            begin
                if (!square_ready)
                begin
                    for (int i = 0; i < NSYM; i++)
                    begin
                        place_symbol(sym_t'(i));
                    end
                    square_ready = 1'b1;
                end
            end
            FN_TEXT:
            begin
                s = char_symbol(c, 1'b1);
                if (square_ready && s >= 0)
                begin
                    if (!held_ok)
                    begin
                        held_sym = sym_t'(s);
                        held_ok  = 1'b1;
                    end
                    else
                    begin
                        held_ok = 1'b0;
                        emit_pair(held_sym, sym_t'(s));
                    end
                end
            end
            default:
            begin
                if (square_ready && held_ok)
                begin
                    held_ok = 1'b0;
                    emit_pair(held_sym, PAD_SYM);
                end
            end
        endcase
    endfunction

    function automatic void check_byte(logic [7:0] ch, logic lst);
        cipher_byte_t want;
        if (cipher_bytes_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: unexpected byte char_out=%h last=%b", $time, ch, lst);
            end
            return;
        end
        want = cipher_bytes_due.pop_front();
        if (ch !== want.ch || lst !== want.last)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: char_out expected %h got %h, last expected %b got %b",
                         $time, want.ch, ch, want.last, lst);
            end
        end
    endfunction

    function automatic void add_item(func_t fn, logic [7:0] ch);
        items_to_send.push_back('{fn, ch});
    endfunction

    function automatic logic [7:0] random_text_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return symbol_char(sym_t'($urandom_range(0, 35)));
            4, 5, 6:    return 8'h61 + 8'($urandom_range(0, 25));
            7:          return 8'h30 + 8'($urandom_range(0, 9));
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sender: bursts of items separated by random gaps; a stalled item is held.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                encipher_item(func, char_in);
                void'(items_to_send.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || items_to_send.size() == 0)
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    func     <= items_to_send[0].fn;
                    char_in  <= items_to_send[0].ch;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: checks each accepted byte and stalls in changing patterns.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_byte(char_out, last);
            end
            if (mode_left == 0)
            begin
                mode_left  = $urandom_range(20, 120);
                stall_mode = stall_mode_t'($urandom_range(0, 2));
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:
                begin
                    out_stall <= 1'b0;
                end
                STALL_RANDOM:
                begin
                    out_stall <= ($urandom_range(0, 2) == 0);
                end
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_left  = $urandom_range(1, 8);
                        run_level = !run_level;
                    end
                    else
                    begin
                        run_left--;
                    end
                    out_stall <= run_level;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** keyed_square_bigram_cipher: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] ch;
        int         pick;

        // Text and end before the square is finished must be dropped.
        add_item(FN_TEXT, 8'h4B);
        add_item(FN_END, 8'h00);
        // Key: letters, a digit, a repeat, lower case, punctuation and the byte extremes.
        add_item(FN_KEY, 8'h5A);
        add_item(FN_KEY, 8'h39);
        add_item(FN_KEY, 8'h61);
        add_item(FN_KEY, 8'h5A);
        add_item(FN_KEY, 8'h23);
        add_item(FN_KEY, 8'h00);
        add_item(FN_KEY, 8'hFF);
        repeat (4)
        begin
            add_item(FN_KEY, symbol_char(sym_t'($urandom_range(0, 35))));
        end
        add_item(FN_FINISH, 8'(($urandom_range(0, 255))));
        // A second finish and a late key character leave the square unchanged.
        add_item(FN_FINISH, 8'hFF);
        add_item(FN_KEY, 8'h51);
        // Equal pair, lower case with a digit, dropped bytes, then an odd leftover padded.
        add_item(FN_TEXT, 8'h41);
        add_item(FN_TEXT, 8'h41);
        add_item(FN_TEXT, 8'h7A);
        add_item(FN_TEXT, 8'h30);
        add_item(FN_TEXT, 8'h21);
        add_item(FN_TEXT, 8'h80);
        add_item(FN_TEXT, 8'h4D);
        add_item(FN_END, 8'hFF);
        add_item(FN_END, 8'h00);

        while (items_to_send.size() < ITEM_COUNT)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                ch = random_text_char();
                add_item(FN_TEXT, ch);
            end
            else if (pick < 92)
            begin
                add_item(FN_END, 8'($urandom_range(0, 255)));
            end
            else
            begin
                add_item(func_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (items_to_send.size() != 0 || in_valid || cipher_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (cipher_bytes_due.size() != 0)
        begin
            $display("%0d expected bytes never arrived", cipher_bytes_due.size());
            mismatches += cipher_bytes_due.size();
        end
        if (mismatches == 0)
        begin
            $display("** keyed_square_bigram_cipher: PASSED **");
        end
        else
        begin
            $display("** keyed_square_bigram_cipher: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
